[src/ece_pkg.sv]
// shared constants and types for the easing curve evaluator
// no dependencies; imported by every module of the block
package ece_pkg;

    localparam int BISECT_STEPS_DEF = 12;
    localparam int FRAC_BITS_DEF    = 16;

    // register stages inside the bezier polynomial unit
    localparam int POLY_LAT = 4;

    typedef enum logic [2:0] {
        MODE_LINEAR = 3'd0,
        MODE_CUBIC_IN = 3'd1,
        MODE_CUBIC_OUT = 3'd2,
        MODE_CUBIC_INOUT = 3'd3,
        MODE_BEZIER = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_CURVE_MODE = 3'd0,
        REG_CTRL_X_FIRST = 3'd1,
        REG_CTRL_Y_FIRST = 3'd2,
        REG_CTRL_X_SECOND = 3'd3,
        REG_CTRL_Y_SECOND = 3'd4
    } t_reg_idx;

endpackage

[src/ece_poly.sv]
// pipelined exact bezier sum 3(N-k)^2 k c1 + 3(N-k) k^2 c2 + k^3 ONE
// depends on ece_pkg; used by ece_cell and ece_tail
module ece_poly import ece_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int KW = BISECT_STEPS + 1,
    localparam int CW = FRAC_BITS + 4,
    localparam int AW = 3 * KW + 2,
    localparam int MW = AW + 1 + CW,
    localparam int SW = MW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [KW-1:0]        i_k,
    input  logic signed [CW-1:0] i_c1,
    input  logic signed [CW-1:0] i_c2,
    output logic signed [SW-1:0] o_sum
);

    localparam logic [KW-1:0] N = KW'(1) << BISECT_STEPS;

    logic [KW-1:0]        w_inv;
    logic [KW-1:0]        r1_k, r1_inv;
    logic [2*KW-1:0]      r1_p, r1_kk;
    logic signed [CW-1:0] r1_c1, r1_c2, r2_c1, r2_c2;
    logic [3*KW-1:0]      w_pi, w_pk;
    logic [AW-1:0]        w_a1, w_a2;
    logic [AW-1:0]        r2_a1, r2_a2;
    logic [3*KW-1:0]      r2_k3, r3_k3;
    logic signed [MW-1:0] r3_m1, r3_m2;
    logic signed [SW-1:0] w_k3s;
    logic signed [SW-1:0] r4_sum;

    assign w_inv = N - i_k;
    assign w_pi  = r1_p * r1_inv;
    assign w_pk  = r1_p * r1_k;
    assign w_a1  = {2'b0, w_pi} + {1'b0, w_pi, 1'b0};
    assign w_a2  = {2'b0, w_pk} + {1'b0, w_pk, 1'b0};
    assign w_k3s = $signed(SW'({r3_k3, {FRAC_BITS{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k   <= i_k;
            r1_inv <= w_inv;
            r1_p   <= w_inv * i_k;
            r1_kk  <= i_k * i_k;
            r1_c1  <= i_c1;
            r1_c2  <= i_c2;
            r2_a1  <= w_a1;
            r2_a2  <= w_a2;
            r2_k3  <= (3*KW)'(r1_kk) * (3*KW)'(r1_k);
            r2_c1  <= r1_c1;
            r2_c2  <= r1_c2;
            r3_m1  <= $signed({1'b0, r2_a1}) * r2_c1;
            r3_m2  <= $signed({1'b0, r2_a2}) * r2_c2;
            r3_k3  <= r2_k3;
            r4_sum <= SW'(r3_m1) + SW'(r3_m2) + w_k3s;
        end
    end

    assign o_sum = r4_sum;

endmodule

[src/ece_front.sv]
// input stage: clamps the fraction and evaluates the cubic curves
// depends on ece_pkg; feeds the bisection chain
module ece_front import ece_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int TW = FRAC_BITS + 1,
    localparam int PW = FRAC_BITS + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [PW-1:0] i_progress,
    input  logic [2:0]           i_mode,
    output logic                 o_valid,
    output logic [TW-1:0]        o_t,
    output logic [TW-1:0]        o_alt,
    output logic                 o_bez
);

    localparam logic [TW-1:0]        ONE   = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]        HALF  = TW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE_S = PW'(1) << FRAC_BITS;
    localparam int                   CWD   = 3 * TW;
    localparam logic [CWD-1:0] RND2 = (CWD'(1) << (2 * FRAC_BITS)) - CWD'(1);
    localparam logic [CWD-1:0] RND3 = (CWD'(1) << (2 * FRAC_BITS + 1)) - CWD'(1);

    logic [TW-1:0]   w_t, w_u, w_alt;
    logic            w_upper;
    logic            r1_valid, r2_valid, r3_valid, r4_valid;
    logic [TW-1:0]   r1_t, r2_t, r3_t, r2_u, r4_t, r4_alt;
    logic [2:0]      r1_mode, r2_mode, r3_mode;
    logic            r2_upper, r3_upper, r4_bez;
    logic [2*TW-1:0] r2_tt;
    logic [CWD-1:0]  r3_c, w_c2f, w_c2c, w_c3c;

    always_comb begin
        if (i_progress[PW-1]) begin
            w_t = '0;
        end else if (i_progress > ONE_S) begin
            w_t = ONE;
        end else begin
            w_t = i_progress[TW-1:0];
        end
    end

    assign w_upper = (r1_t >= HALF);

    always_comb begin
        if (r1_mode == MODE_CUBIC_OUT) begin
            w_u = ONE - r1_t;
        end else if (r1_mode == MODE_CUBIC_INOUT && w_upper) begin
            w_u = TW'({ONE - r1_t, 1'b0});
        end else begin
            w_u = r1_t;
        end
    end

    // ceil of a non-negative value gives floor of its negation
    assign w_c2f = r3_c >> (2 * FRAC_BITS);
    assign w_c2c = (r3_c + RND2) >> (2 * FRAC_BITS);
    assign w_c3c = (r3_c + RND3) >> (2 * FRAC_BITS + 1);

    always_comb begin
        unique case (r3_mode)
            MODE_CUBIC_IN:  w_alt = TW'(w_c2f);
            MODE_CUBIC_OUT: w_alt = ONE - TW'(w_c2c);
            MODE_CUBIC_INOUT: begin
                if (r3_upper) begin
                    w_alt = ONE - TW'(w_c3c);
                end else begin
                    w_alt = TW'(r3_c >> (2 * FRAC_BITS - 2));
                end
            end
            default:        w_alt = r3_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t     <= w_t;
            r1_mode  <= i_mode;
            r2_t     <= r1_t;
            r2_u     <= w_u;
            r2_tt    <= w_u * w_u;
            r2_mode  <= r1_mode;
            r2_upper <= w_upper;
            r3_c     <= CWD'(r2_tt) * CWD'(r2_u);
            r3_t     <= r2_t;
            r3_mode  <= r2_mode;
            r3_upper <= r2_upper;
            r4_t     <= r3_t;
            r4_alt   <= w_alt;
            r4_bez   <= (r3_mode == MODE_BEZIER);
        end
    end

    assign o_valid = r4_valid;
    assign o_t     = r4_t;
    assign o_alt   = r4_alt;
    assign o_bez   = r4_bez;

endmodule

[src/ece_cell.sv]
// one bisection step on x(t): evaluates x at the midpoint and narrows lo..hi
// depends on ece_pkg and ece_poly
module ece_cell import ece_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int KW = BISECT_STEPS + 1,
    localparam int TW = FRAC_BITS + 1,
    localparam int CW = FRAC_BITS + 4,
    localparam int SW = 3 * KW + 2 + 1 + CW + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [KW-1:0] i_lo,
    input  logic [KW-1:0] i_hi,
    input  logic [TW-1:0] i_t,
    input  logic [TW-1:0] i_alt,
    input  logic          i_bez,
    input  logic [TW-1:0] i_x1,
    input  logic [TW-1:0] i_x2,
    output logic          o_valid,
    output logic [KW-1:0] o_lo,
    output logic [KW-1:0] o_hi,
    output logic [KW-1:0] o_k,
    output logic [TW-1:0] o_t,
    output logic [TW-1:0] o_alt,
    output logic          o_bez
);

    logic [KW:0]          w_mid;
    logic [KW-1:0]        w_k;
    logic signed [SW-1:0] w_sum, w_goal;
    logic                 w_less;

    logic          r_d_valid [POLY_LAT];
    logic [KW-1:0] r_d_lo    [POLY_LAT];
    logic [KW-1:0] r_d_hi    [POLY_LAT];
    logic [KW-1:0] r_d_k     [POLY_LAT];
    logic [TW-1:0] r_d_t     [POLY_LAT];
    logic [TW-1:0] r_d_alt   [POLY_LAT];
    logic          r_d_bez   [POLY_LAT];

    logic          r_valid, r_bez;
    logic [KW-1:0] r_lo, r_hi, r_k;
    logic [TW-1:0] r_t, r_alt;

    assign w_mid = {1'b0, i_lo} + {1'b0, i_hi};
    assign w_k   = w_mid[KW:1];

    ece_poly #(
        .BISECT_STEPS (BISECT_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_poly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_k   (w_k),
        .i_c1  ($signed({3'b000, i_x1})),
        .i_c2  ($signed({3'b000, i_x2})),
        .o_sum (w_sum)
    );

    // target scaled by N^3
    assign w_goal = $signed(SW'({r_d_t[POLY_LAT-1], {(3 * BISECT_STEPS){1'b0}}}));
    assign w_less = (w_sum < w_goal);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POLY_LAT; i++) begin
                r_d_valid[i] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid[0] <= i_valid;
            for (int i = 1; i < POLY_LAT; i++) begin
                r_d_valid[i] <= r_d_valid[i-1];
            end
            r_valid <= r_d_valid[POLY_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_lo[0]  <= i_lo;
            r_d_hi[0]  <= i_hi;
            r_d_k[0]   <= w_k;
            r_d_t[0]   <= i_t;
            r_d_alt[0] <= i_alt;
            r_d_bez[0] <= i_bez;
            for (int i = 1; i < POLY_LAT; i++) begin
                r_d_lo[i]  <= r_d_lo[i-1];
                r_d_hi[i]  <= r_d_hi[i-1];
                r_d_k[i]   <= r_d_k[i-1];
                r_d_t[i]   <= r_d_t[i-1];
                r_d_alt[i] <= r_d_alt[i-1];
                r_d_bez[i] <= r_d_bez[i-1];
            end
            r_lo  <= w_less ? r_d_k[POLY_LAT-1] : r_d_lo[POLY_LAT-1];
            r_hi  <= w_less ? r_d_hi[POLY_LAT-1] : r_d_k[POLY_LAT-1];
            r_k   <= r_d_k[POLY_LAT-1];
            r_t   <= r_d_t[POLY_LAT-1];
            r_alt <= r_d_alt[POLY_LAT-1];
            r_bez <= r_d_bez[POLY_LAT-1];
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_k     = r_k;
    assign o_t     = r_t;
    assign o_alt   = r_alt;
    assign o_bez   = r_bez;

endmodule

[src/ece_tail.sv]
// evaluates y(t) at the final midpoint, clamps it and picks the curve result
// depends on ece_pkg and ece_poly; holds the output register
module ece_tail import ece_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int KW = BISECT_STEPS + 1,
    localparam int TW = FRAC_BITS + 1,
    localparam int YW = FRAC_BITS + 3,
    localparam int CW = FRAC_BITS + 4,
    localparam int SW = 3 * KW + 2 + 1 + CW + 2,
    localparam int RW = SW - 3 * BISECT_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [KW-1:0]        i_k,
    input  logic [TW-1:0]        i_alt,
    input  logic                 i_bez,
    input  logic signed [YW-1:0] i_y1,
    input  logic signed [YW-1:0] i_y2,
    output logic                 o_valid,
    output logic [TW-1:0]        o_result
);

    localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]        ONE   = TW'(1) << FRAC_BITS;

    logic signed [SW-1:0] w_sum;
    logic signed [RW-1:0] w_y;
    logic [TW-1:0]        w_yc;

    logic          r_d_valid [POLY_LAT];
    logic [TW-1:0] r_d_alt   [POLY_LAT];
    logic          r_d_bez   [POLY_LAT];
    logic          r_valid;
    logic [TW-1:0] r_result;

    ece_poly #(
        .BISECT_STEPS (BISECT_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_poly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_k   (i_k),
        .i_c1  (CW'(i_y1)),
        .i_c2  (CW'(i_y2)),
        .o_sum (w_sum)
    );

    // floor shift back to the fraction grid
    assign w_y = RW'(w_sum >>> (3 * BISECT_STEPS));

    always_comb begin
        if (w_y[RW-1]) begin
            w_yc = '0;
        end else if (w_y > ONE_R) begin
            w_yc = ONE;
        end else begin
            w_yc = w_y[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POLY_LAT; i++) begin
                r_d_valid[i] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid[0] <= i_valid;
            for (int i = 1; i < POLY_LAT; i++) begin
                r_d_valid[i] <= r_d_valid[i-1];
            end
            r_valid <= r_d_valid[POLY_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_alt[0] <= i_alt;
            r_d_bez[0] <= i_bez;
            for (int i = 1; i < POLY_LAT; i++) begin
                r_d_alt[i] <= r_d_alt[i-1];
                r_d_bez[i] <= r_d_bez[i-1];
            end
            r_result <= r_d_bez[POLY_LAT-1] ? w_yc : r_d_alt[POLY_LAT-1];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[src/easing_curve_evaluator_core.sv]
// top level of the easing curve evaluator: register port, front stage,
// bisection chain and output stage; depends on ece_pkg and all ece_ modules
//
// Maps a signed Q16 fraction, clamped to 0..1, to eased progress 0..1 in Q16
// under the curve that curve_mode selects (codes 5 to 7 behave as linear).
// The pipeline takes one request per cycle unless a valid result is stalled
// at the output. It has four front stages for the clamp and cubic curves,
// one cell of five stages per bisection step, each built around a
// four-stage multiplier pipeline, and five stages for y(t) and the output
// register. All curves take the same path and latency. A stall of a valid
// output result holds the whole pipeline. Registers sit at byte addresses
// 4*i and are to be written only while no request is in flight.
module easing_curve_evaluator_core import ece_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int KW = BISECT_STEPS + 1,
    localparam int TW = FRAC_BITS + 1,
    localparam int YW = FRAC_BITS + 3,
    localparam int PW = FRAC_BITS + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [PW-1:0] i_progress_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TW-1:0]        o_eased_out
);

    localparam logic [KW-1:0] N   = KW'(1) << BISECT_STEPS;
    localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

    logic                 w_bez_mode;
    logic [2:0]           r_mode;
    logic [TW-1:0]        r_x1, r_x2;
    logic signed [YW-1:0] r_y1, r_y2;
    logic                 w_wr, w_en;
    logic [2:0]           w_idx;

    logic          w_valid [BISECT_STEPS+1];
    logic [KW-1:0] w_lo    [BISECT_STEPS+1];
    logic [KW-1:0] w_hi    [BISECT_STEPS+1];
    logic [KW-1:0] w_k     [BISECT_STEPS+1];
    logic [TW-1:0] w_t     [BISECT_STEPS+1];
    logic [TW-1:0] w_alt   [BISECT_STEPS+1];
    logic          w_bez   [BISECT_STEPS+1];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_x1   <= '0;
            r_y1   <= '0;
            r_x2   <= ONE;
            r_y2   <= YW'(ONE);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CURVE_MODE:    r_mode <= pwdata[2:0];
                REG_CTRL_X_FIRST:  r_x1   <= pwdata[TW-1:0];
                REG_CTRL_Y_FIRST:  r_y1   <= $signed(pwdata[YW-1:0]);
                REG_CTRL_X_SECOND: r_x2   <= pwdata[TW-1:0];
                REG_CTRL_Y_SECOND: r_y2   <= $signed(pwdata[YW-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CURVE_MODE:    prdata = 32'(r_mode);
            REG_CTRL_X_FIRST:  prdata = 32'(r_x1);
            REG_CTRL_Y_FIRST:  prdata = 32'(r_y1);
            REG_CTRL_X_SECOND: prdata = 32'(r_x2);
            REG_CTRL_Y_SECOND: prdata = 32'(r_y2);
            default:           prdata = '0;
        endcase
    end

    // the whole pipeline moves unless a finished result is held back
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    ece_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in_valid),
        .i_progress (i_progress_in),
        .i_mode     (r_mode),
        .o_valid    (w_valid[0]),
        .o_t        (w_t[0]),
        .o_alt      (w_alt[0]),
        .o_bez      (w_bez[0])
    );

    assign w_lo[0] = '0;
    assign w_hi[0] = N;
    assign w_k[0]  = '0;

    for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_cell
        ece_cell #(
            .BISECT_STEPS (BISECT_STEPS),
            .FRAC_BITS    (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_lo    (w_lo[g]),
            .i_hi    (w_hi[g]),
            .i_t     (w_t[g]),
            .i_alt   (w_alt[g]),
            .i_bez   (w_bez[g]),
            .i_x1    (r_x1),
            .i_x2    (r_x2),
            .o_valid (w_valid[g+1]),
            .o_lo    (w_lo[g+1]),
            .o_hi    (w_hi[g+1]),
            .o_k     (w_k[g+1]),
            .o_t     (w_t[g+1]),
            .o_alt   (w_alt[g+1]),
            .o_bez   (w_bez[g+1])
        );
    end

    ece_tail #(
        .BISECT_STEPS (BISECT_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_tail (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[BISECT_STEPS]),
        .i_k      (w_k[BISECT_STEPS]),
        .i_alt    (w_alt[BISECT_STEPS]),
        .i_bez    (w_bez[BISECT_STEPS]),
        .i_y1     (r_y1),
        .i_y2     (r_y2),
        .o_valid  (o_out_valid),
        .o_result (o_eased_out)
    );

    assign w_bez_mode = (r_mode == MODE_BEZIER);

`ifndef ASSERT_OFF
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_eased_out <= ONE))
        else $error("eased result above one");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_bisect_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[BISECT_STEPS] && w_bez_mode) |->
        (w_hi[BISECT_STEPS] > w_lo[BISECT_STEPS]))
        else $error("bisection interval collapsed");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");
`endif

endmodule
